[rtl/core/nlt_pkg.sv]
// ----------------------------------------------------------------------------
// nlt_pkg
// Shared types and constants for the node liveness tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package nlt_pkg;

  localparam int unsigned NODES  = 64;
  localparam int unsigned NODE_W = (NODES > 1) ? $clog2(NODES) : 1;

  localparam logic [6:0] PCT_SCALE   = 7'd100;
  localparam logic [7:0] RMCP_TAG_TOP = 8'hFF;  // counter value that folds to 0 (mod 255)
  localparam logic [8:0] RECV_MAX    = 9'd511;
  localparam logic [7:0] CONSEC_MAX  = 8'd255;
  localparam logic [31:0] TIMEOUT_RST = 32'd5000;

  // discovery codes
  localparam logic [1:0] DISC_NONE  = 2'd0;
  localparam logic [1:0] DISC_FOUND = 2'd1;
  localparam logic [1:0] DISC_BAD   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_WINDOW  = 3'd0;
  localparam logic [2:0] REG_LOSS    = 3'd1;
  localparam logic [2:0] REG_CONSEC  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_IPMI    = 3'd4;

  typedef struct packed {
    logic [5:0]  node;
    logic        send_round;
    logic        pong_ok;
    logic [31:0] now_ms;
  } nlt_in_t;

  typedef struct packed {
    logic [5:0] node_out;
    logic       send_ping;
    logic [7:0] ping_tag;
    logic [1:0] reach_state;
    logic       link_fault;
  } nlt_out_t;

  typedef struct packed {
    logic [7:0]  sent;
    logic [8:0]  recv;
    logic [7:0]  consec;
    logic        got_pong;
    logic [7:0]  tag_cnt;
    logic        link_bad;
    logic [1:0]  nstate;
    logic [31:0] last_ms;
  } nlt_row_t;

  typedef enum logic [1:0] {
    OP_SUB = 2'b01,
    OP_MUL = 2'b10
  } nlt_op_e;

  typedef struct packed {
    nlt_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } nlt_calc_req_t;

  typedef struct packed {
    logic [31:0] res;
    logic        borrow;
  } nlt_calc_rsp_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_MUL_A = 7'b0000100,
    ST_MUL_B = 7'b0001000,
    ST_LOSS  = 7'b0010000,
    ST_TDIFF = 7'b0100000,
    ST_TDONE = 7'b1000000
  } nlt_state_e;

endpackage

`default_nettype wire

[rtl/core/node_liveness_tracker.sv]
// ----------------------------------------------------------------------------
// node_liveness_tracker
// Per-node ping/pong liveness table with loss window and timeout checks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid_i/in_stall_o | in_req_i  (nlt_in_t)
//  out     | from block| out_valid_o/out_stall_i | out_rsp_o (nlt_out_t)
//  cfg     | to block  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Each request runs through the accepting cycle, which issues the row read,
//  then six passes through the shared subtract/multiply unit, the last of
//  which also writes the row back.
//  The next request is taken the cycle after the row is written; a result
//  waiting on out_stall_i holds back only the final write-back step.
//  Reset clears the per-row valid bits and the config, but sets the timeout
//  to TIMEOUT_RST; a row not yet written reads as all zero. Config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module node_liveness_tracker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire nlt_pkg::nlt_in_t in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output nlt_pkg::nlt_out_t    out_rsp_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);
  import nlt_pkg::*;

  // configuration
  logic [7:0]  window_q;
  logic [6:0]  loss_pct_q;
  logic [7:0]  consec_q;
  logic [31:0] timeout_q;
  logic        ipmi_q;

  nlt_state_e state_q, state_d;
  nlt_in_t    in_q;
  nlt_row_t   row_q, row_m, rd_row, new_row;
  logic       hit_q;
  logic       node_ok_q;
  logic [7:0] diff_q;
  logic       r_gt_s_q;
  logic [15:0] p1_q, p2_q;
  logic       loss_bad_q;
  logic [31:0] tdiff_q;
  logic [NODES-1:0] valid_q;
  logic       out_valid_q;
  nlt_out_t   out_q, out_d;

  logic in_fire, out_free, finish;
  logic [NODE_W-1:0] waddr;
  nlt_calc_req_t calc_req;
  nlt_calc_rsp_t calc_rsp;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !(out_valid_q && out_stall_i);
  assign finish      = (state_q == ST_TDONE) && out_free;
  assign waddr       = in_q.node[NODE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      loss_pct_q <= '0;
      consec_q   <= '0;
      timeout_q  <= TIMEOUT_RST;
      ipmi_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WINDOW:  window_q   <= cfg_data_i[7:0];
        REG_LOSS:    loss_pct_q <= cfg_data_i[6:0];
        REG_CONSEC:  consec_q   <= cfg_data_i[7:0];
        REG_TIMEOUT: timeout_q  <= cfg_data_i;
        REG_IPMI:    ipmi_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  nlt_row_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (finish && node_ok_q),
    .waddr_i (waddr),
    .wdata_i (new_row),
    .re_i    (in_fire),
    .raddr_i (in_req_i.node[NODE_W-1:0]),
    .rdata_o (rd_row)
  );

  nlt_calc u_calc (
    .req_i (calc_req),
    .rsp_o (calc_rsp)
  );

  assign row_m = hit_q ? rd_row : '0;

  // operand selection for the shared unit
  always_comb begin
    calc_req.op = OP_SUB;
    calc_req.a  = '0;
    calc_req.b  = '0;
    case (state_q)
      ST_LOAD: begin
        calc_req.a = {24'b0, row_m.sent};
        calc_req.b = {23'b0, row_m.recv};
      end
      ST_MUL_A: begin
        calc_req.op = OP_MUL;
        calc_req.a  = {25'b0, PCT_SCALE};
        calc_req.b  = {24'b0, diff_q};
      end
      ST_MUL_B: begin
        calc_req.op = OP_MUL;
        calc_req.a  = {25'b0, loss_pct_q};
        calc_req.b  = {24'b0, row_q.sent};
      end
      ST_LOSS: begin
        calc_req.a = {16'b0, p2_q};
        calc_req.b = {16'b0, p1_q};
      end
      ST_TDIFF: begin
        calc_req.a = in_q.now_ms;
        calc_req.b = in_q.pong_ok ? in_q.now_ms : row_q.last_ms;
      end
      ST_TDONE: begin
        calc_req.a = tdiff_q;
        calc_req.b = timeout_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_MUL_A;
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_LOSS;
      ST_LOSS:  state_d = ST_TDIFF;
      ST_TDIFF: state_d = ST_TDONE;
      ST_TDONE: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (finish && node_ok_q) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (in_fire) begin
      hit_q <= valid_q[in_req_i.node[NODE_W-1:0]];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q      <= in_req_i;
      node_ok_q <= ({1'b0, in_req_i.node} < 7'(NODES));
    end
    case (state_q)
      ST_LOAD: begin
        row_q    <= row_m;
        diff_q   <= calc_rsp.res[7:0];
        r_gt_s_q <= calc_rsp.borrow;
      end
      ST_MUL_A: p1_q       <= calc_rsp.res[15:0];
      ST_MUL_B: p2_q       <= calc_rsp.res[15:0];
      ST_LOSS:  loss_bad_q <= calc_rsp.borrow;
      ST_TDIFF: tdiff_q    <= calc_rsp.res;
      default: ;
    endcase
  end

  // row update, evaluated in the last step
  logic       loss_on, consec_on, close, timed_out;
  logic       lb1, got1;
  logic [7:0] sent1, consec1, tag1, tag_out;
  logic [8:0] recv1;
  logic [1:0] state2;

  always_comb begin
    loss_on   = (window_q != '0) && (loss_pct_q != '0);
    consec_on = (consec_q != '0);
    close     = in_q.send_round && loss_on && (row_q.sent == window_q);
    timed_out = !calc_rsp.borrow;

    lb1   = close ? (r_gt_s_q || loss_bad_q) : row_q.link_bad;
    sent1 = close ? 8'd0 : row_q.sent;
    recv1 = close ? 9'd0 : row_q.recv;

    consec1 = row_q.consec;
    got1    = row_q.got_pong;
    if (in_q.send_round && consec_on) begin
      if (!row_q.got_pong) consec1 = 8'd0;
      got1 = 1'b0;
    end

    tag1 = in_q.send_round ? row_q.tag_cnt + 8'd1 : row_q.tag_cnt;
    if (!in_q.send_round) begin
      tag_out = 8'd0;
    end else if (ipmi_q) begin
      tag_out = {2'b0, tag1[5:0]};
    end else begin
      tag_out = (tag1 == RMCP_TAG_TOP) ? 8'd0 : tag1;
    end

    new_row          = row_q;
    new_row.link_bad = lb1;
    new_row.tag_cnt  = tag1;
    new_row.sent     = (in_q.send_round && loss_on) ? sent1 + 8'd1 : sent1;
    new_row.recv     = recv1;
    new_row.consec   = consec1;
    new_row.got_pong = got1;
    state2           = row_q.nstate;

    if (in_q.pong_ok) begin
      if (loss_on && (recv1 < RECV_MAX)) new_row.recv = recv1 + 9'd1;
      if (consec_on) begin
        if (!got1 && (consec1 < CONSEC_MAX)) new_row.consec = consec1 + 8'd1;
        new_row.got_pong = 1'b1;
      end
      if (!loss_on || !lb1) begin
        state2 = DISC_FOUND;
      end else if (consec_on && (new_row.consec >= consec_q)) begin
        state2 = DISC_FOUND;
      end else begin
        state2 = DISC_BAD;
      end
      new_row.last_ms = in_q.now_ms;
    end
    new_row.nstate = timed_out ? DISC_NONE : state2;

    out_d.node_out = in_q.node;
    if (node_ok_q) begin
      out_d.send_ping   = in_q.send_round;
      out_d.ping_tag    = tag_out;
      out_d.reach_state = new_row.nstate;
      out_d.link_fault  = lb1;
    end else begin
      out_d.send_ping   = 1'b0;
      out_d.ping_tag    = '0;
      out_d.reach_state = DISC_NONE;
      out_d.link_fault  = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

[rtl/core/nlt_row_mem.sv]
// ----------------------------------------------------------------------------
// nlt_row_mem
// One row per node: single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nlt_row_mem (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [nlt_pkg::NODE_W-1:0] waddr_i,
  input  wire nlt_pkg::nlt_row_t         wdata_i,
  input  wire logic                      re_i,
  input  wire logic [nlt_pkg::NODE_W-1:0] raddr_i,
  output nlt_pkg::nlt_row_t              rdata_o
);
  import nlt_pkg::*;

  nlt_row_t mem_q [NODES];
  nlt_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/nlt_calc.sv]
// ----------------------------------------------------------------------------
// nlt_calc
// Shared arithmetic unit: 32-bit subtract with borrow, or 8x8 multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module nlt_calc (
  input  wire nlt_pkg::nlt_calc_req_t req_i,
  output nlt_pkg::nlt_calc_rsp_t      rsp_o
);
  import nlt_pkg::*;

  logic [32:0] diff;
  logic [15:0] prod;

  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign prod = req_i.a[7:0] * req_i.b[7:0];

  always_comb begin
    case (req_i.op)
      OP_SUB: begin
        rsp_o.res    = diff[31:0];
        rsp_o.borrow = diff[32];
      end
      OP_MUL: begin
        rsp_o.res    = {16'b0, prod};
        rsp_o.borrow = 1'b0;
      end
      default: begin
        rsp_o.res    = '0;
        rsp_o.borrow = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/nlt_checker.sv]
// ----------------------------------------------------------------------------
// nlt_checker
// Port-level checks for the node liveness tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nlt_port_checks (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire nlt_pkg::nlt_out_t out_rsp_o
);
  import nlt_pkg::*;

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result dropped or changed");

  // one request at a time: busy right after taking one
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous still in work");

  // a new result only appears after the block has been working
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in work");

  // no ping, no tag
  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.send_ping |-> out_rsp_o.ping_tag == 8'd0)
    else $error("tag set without a ping");

endmodule

bind node_liveness_tracker nlt_port_checks u_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

[bench/nlt_checker.sv]
// ----------------------------------------------------------------------------
// nlt_checker
// Watches the request, result and register channels of the liveness tracker.
// Each accepted request is run through a private copy of the per-node table
// and each result is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nlt_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  nlt_pkg::nlt_in_t in_req_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  nlt_pkg::nlt_out_t out_rsp_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               pending_o,
  output int               errors_o
);
  import nlt_pkg::*;

  localparam int unsigned IPMI_TAG_MOD = 64;
  localparam int unsigned RMCP_TAG_MOD = 255;

  // register copies
  logic [7:0]  window_q;
  logic [6:0]  loss_pct_q;
  logic [7:0]  consec_need_q;
  logic [31:0] timeout_q;
  logic        ipmi_q;

  // per-node rows
  logic [7:0]  sent_q     [NODES];
  logic [8:0]  recv_q     [NODES];
  logic [7:0]  consec_q   [NODES];
  logic        got_pong_q [NODES];
  logic [7:0]  tag_cnt_q  [NODES];
  logic        link_bad_q [NODES];
  logic [1:0]  disc_q     [NODES];
  logic [31:0] last_ms_q  [NODES];

  nlt_out_t rsp_due_q [$];
  nlt_out_t seen_rsp, due_rsp;
  int       err_cnt;
  int       row;

  assign errors_o = err_cnt;

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // Applies one event to the table copy and returns the result it should give
  function automatic nlt_out_t track_event(input nlt_in_t ev);
    int unsigned n, s, r;
    logic        loss_on;
    logic [7:0]  tag;
    nlt_out_t    res;
    n       = ev.node;
    loss_on = (window_q != 0) && (loss_pct_q != 0);
    tag     = '0;

    if (ev.send_round) begin
      if (loss_on && sent_q[n] == window_q) begin
        s = sent_q[n];
        r = recv_q[n];
        if (r > s) begin
          link_bad_q[n] = 1'b1;
        end else begin
          link_bad_q[n] = (32'(PCT_SCALE) * (s - r)) > (32'(loss_pct_q) * s);
        end
        sent_q[n] = '0;
        recv_q[n] = '0;
      end
      if (consec_need_q != 0) begin
        if (!got_pong_q[n]) consec_q[n] = '0;
        got_pong_q[n] = 1'b0;
      end
      tag_cnt_q[n] = tag_cnt_q[n] + 8'd1;
      tag = ipmi_q ? 8'(tag_cnt_q[n] % IPMI_TAG_MOD) : 8'(tag_cnt_q[n] % RMCP_TAG_MOD);
      if (loss_on) sent_q[n] = sent_q[n] + 8'd1;
    end

    if (ev.pong_ok) begin
      if (loss_on && recv_q[n] < RECV_MAX) recv_q[n] = recv_q[n] + 9'd1;
      if (consec_need_q != 0) begin
        if (!got_pong_q[n] && consec_q[n] < CONSEC_MAX) consec_q[n] = consec_q[n] + 8'd1;
        got_pong_q[n] = 1'b1;
      end
      if (!loss_on || !link_bad_q[n]) begin
        disc_q[n] = DISC_FOUND;
      end else if (consec_need_q != 0 && consec_q[n] >= consec_need_q) begin
        disc_q[n] = DISC_FOUND;   // rescued by a run of pongs
      end else begin
        disc_q[n] = DISC_BAD;
      end
      last_ms_q[n] = ev.now_ms;
    end

    // silence measured modulo 2^32
    if (32'(ev.now_ms - last_ms_q[n]) >= timeout_q) disc_q[n] = DISC_NONE;

    res.node_out    = ev.node;
    res.send_ping   = ev.send_round;
    res.ping_tag    = tag;
    res.reach_state = disc_q[n];
    res.link_fault  = link_bad_q[n];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      = '0;
      loss_pct_q    = '0;
      consec_need_q = '0;
      timeout_q     = TIMEOUT_RST;
      ipmi_q        = 1'b0;
      for (row = 0; row < NODES; row++) begin
        sent_q[row]     = '0;
        recv_q[row]     = '0;
        consec_q[row]   = '0;
        got_pong_q[row] = 1'b0;
        tag_cnt_q[row]  = '0;
        link_bad_q[row] = 1'b0;
        disc_q[row]     = DISC_NONE;
        last_ms_q[row]  = '0;
      end
      rsp_due_q.delete();
      err_cnt   = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WINDOW:  window_q      = cfg_data_i[7:0];
          REG_LOSS:    loss_pct_q    = cfg_data_i[6:0];
          REG_CONSEC:  consec_need_q = cfg_data_i[7:0];
          REG_TIMEOUT: timeout_q     = cfg_data_i;
          REG_IPMI:    ipmi_q        = cfg_data_i[0];
          default: ;
        endcase
      end

      // results first, so a result in the same cycle as its request is caught
      if (out_valid_i && !out_stall_i) begin
        seen_rsp = out_rsp_i;
        if (rsp_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result for node %0d", seen_rsp.node_out));
        end else begin
          due_rsp = rsp_due_q.pop_front();
          if (seen_rsp.node_out !== due_rsp.node_out)
            report_mismatch($sformatf("node_out got %0d want %0d",
                                      seen_rsp.node_out, due_rsp.node_out));
          if (seen_rsp.send_ping !== due_rsp.send_ping)
            report_mismatch($sformatf("node %0d send_ping got %0b want %0b",
                                      due_rsp.node_out, seen_rsp.send_ping,
                                      due_rsp.send_ping));
          if (seen_rsp.ping_tag !== due_rsp.ping_tag)
            report_mismatch($sformatf("node %0d ping_tag got %0d want %0d",
                                      due_rsp.node_out, seen_rsp.ping_tag,
                                      due_rsp.ping_tag));
          if (seen_rsp.reach_state !== due_rsp.reach_state)
            report_mismatch($sformatf("node %0d reach_state got %0d want %0d",
                                      due_rsp.node_out, seen_rsp.reach_state,
                                      due_rsp.reach_state));
          if (seen_rsp.link_fault !== due_rsp.link_fault)
            report_mismatch($sformatf("node %0d link_fault got %0b want %0b",
                                      due_rsp.node_out, seen_rsp.link_fault,
                                      due_rsp.link_fault));
        end
      end

      if (in_valid_i && !in_stall_i) rsp_due_q.push_back(track_event(in_req_i));

      pending_o = rsp_due_q.size();
    end
  end

endmodule

[bench/tb_node_liveness_tracker.sv]
// ----------------------------------------------------------------------------
// tb_node_liveness_tracker
// Drives directed and random ping/pong events into the liveness tracker over
// several register settings and idling patterns; nlt_checker does the checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_node_liveness_tracker;
  import nlt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  nlt_in_t     in_req;
  logic        out_valid;
  logic        out_stall;
  nlt_out_t    out_rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int pending, errors;
  int send_idle_pct, stall_pct;

  logic in_acc  = 1'b0;
  logic cfg_acc = 1'b0;

  logic [31:0] sim_ms;
  logic [5:0]  pool [4];
  logic        responsive [4];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  node_liveness_tracker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  nlt_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // handshakes seen at the rising edge, read back at the falling edge
  always @(posedge clk) begin
    in_acc  <= in_valid && !in_stall;
    cfg_acc <= cfg_valid && cfg_ready;
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 47; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 47; end
      3:       begin send_idle_pct = 38; stall_pct = 38; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_req(input nlt_in_t req);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(negedge clk); while (!in_acc);
  endtask

  task automatic drive_event(input logic [5:0] node, input logic send, input logic pong,
                             input logic [31:0] now);
    nlt_in_t req;
    req.node       = node;
    req.send_round = send;
    req.pong_ok    = pong;
    req.now_ms     = now;
    push_req(req);
  endtask

  // all results in, then a margin well beyond the row update
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_acc);
  endtask

  task automatic set_config(input logic [7:0] window, input logic [6:0] loss_pct,
                            input logic [7:0] consec, input logic [31:0] timeout,
                            input logic ipmi);
    cfg_write(REG_WINDOW, 32'(window));
    cfg_write(REG_LOSS, 32'(loss_pct));
    cfg_write(REG_CONSEC, 32'(consec));
    cfg_write(REG_TIMEOUT, timeout);
    cfg_write(REG_IPMI, 32'(ipmi));
    cfg_valid <= 1'b0;
  endtask

  // Mostly a few hot nodes whose pong rate swings between good and lossy,
  // so loss windows close both ways and runs of pongs rescue bad links.
  // The sweep hammers node 63 with pings to take its tag through a full wrap.
  task automatic random_events(input int count, input logic sweep);
    nlt_in_t req;
    int      k, pi, dice;
    for (k = 0; k < count; k++) begin
      if (sweep) begin
        req.node       = ($urandom_range(0, 99) < 97) ? 6'd63 : 6'd62;
        req.send_round = $urandom_range(0, 99) < 97;
        req.pong_ok    = 1'($urandom_range(0, 1));
      end else begin
        pi = $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 4) responsive[pi] = !responsive[pi];
        if ($urandom_range(0, 99) < 80) begin
          req.node    = pool[pi];
          req.pong_ok = $urandom_range(0, 99) < (responsive[pi] ? 90 : 15);
        end else begin
          req.node    = 6'($urandom_range(0, 63));
          req.pong_ok = 1'($urandom_range(0, 1));
        end
        req.send_round = $urandom_range(0, 99) < 60;
      end
      dice = $urandom_range(0, 99);
      if (dice < 2) begin
        sim_ms = $urandom;
      end else if (dice < 5) begin
        sim_ms = sim_ms + $urandom_range(0, 20000);
      end else begin
        sim_ms = sim_ms + $urandom_range(0, 400);
      end
      req.now_ms = sim_ms;
      push_req(req);
    end
  endtask

  initial begin
    int phase;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sim_ms    = '0;
    set_idling(0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: 5000 ms timeout, loss heuristic off, modulus-255 tags
    drive_event(6'd0,  1'b1, 1'b0, 32'd0);
    drive_event(6'd0,  1'b0, 1'b1, 32'd100);
    drive_event(6'd0,  1'b0, 1'b0, 32'd5100);        // silent exactly the limit
    drive_event(6'd63, 1'b1, 1'b1, 32'hFFFF_FFFF);
    drive_event(6'd63, 1'b0, 1'b0, 32'd4998);        // distance across the wrap
    drive_event(6'd63, 1'b0, 1'b0, 32'd4999);
    drive_event(6'd42, 1'b0, 1'b1, 32'hAAAA_5555);

    wait_idle();
    set_config(8'd2, 7'd50, 8'd2, 32'd1000, 1'b1);
    // window closes lossy, then a pong run rescues the link, then closes clean
    drive_event(6'd1, 1'b1, 1'b0, 32'd10);
    drive_event(6'd1, 1'b1, 1'b0, 32'd20);
    drive_event(6'd1, 1'b1, 1'b0, 32'd30);
    drive_event(6'd1, 1'b0, 1'b1, 32'd40);
    drive_event(6'd1, 1'b1, 1'b1, 32'd50);
    drive_event(6'd1, 1'b1, 1'b1, 32'd60);
    // more pongs than pings in the window
    drive_event(6'd2, 1'b0, 1'b1, 32'd100);
    drive_event(6'd2, 1'b0, 1'b1, 32'd110);
    drive_event(6'd2, 1'b0, 1'b1, 32'd120);
    drive_event(6'd2, 1'b1, 1'b0, 32'd130);
    drive_event(6'd2, 1'b1, 1'b0, 32'd140);
    drive_event(6'd2, 1'b1, 1'b0, 32'd150);

    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0: set_config(8'd255, 7'd100, 8'd255, 32'hFFFF_FFFF, 1'b0);
        1: set_config(8'd4, 7'd30, 8'd3, 32'd2000, 1'b0);
        2: set_config(8'd1, 7'd1, 8'd1, 32'd500, 1'b1);
        3: set_config(8'd0, 7'd50, 8'd2, 32'd0, 1'b1);
        4: set_config(8'd3, 7'd0, 8'd0, 32'd1000, 1'b0);
        5: set_config(8'($urandom_range(1, 8)), 7'($urandom_range(1, 100)),
                      8'($urandom_range(1, 6)), 32'($urandom_range(200, 4000)),
                      1'($urandom_range(0, 1)));
        6: set_config(8'd2, 7'd100, 8'd5, 32'd3000, 1'b1);
        default: set_config(8'd6, 7'd50, 8'd0, 32'd1500, 1'b0);
      endcase
      for (int i = 0; i < 4; i++) begin
        pool[i]       = 6'($urandom_range(0, 63));
        responsive[i] = 1'b1;
      end
      set_idling(phase % 4);
      random_events((phase == 0) ? 300 : 115, phase == 0);
    end

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
